// ===== rtl/gar_pkg.sv =====
// Package for the GAE advantage recurrence unit.
// Holds widths, register codes, reset values, item/state structs and the env wrap-table builder.
// No dependencies.
package gar_pkg;

    localparam int ENV_SLOTS_DEFAULT = 16;
    localparam int ENV_IN_W         = 4;
    localparam int DATA_W           = 32;
    localparam int Q15_W            = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;
    localparam int ENV_TAB_N        = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd1;

    localparam logic [Q15_W-1:0] Q15_ONE      = 16'd32768;
    localparam logic [Q15_W-1:0] GAMMA_RESET  = 16'd32440;
    localparam logic [Q15_W-1:0] LAMBDA_RESET = 16'd31130;
    localparam logic [Q15_W-1:0] GL_RESET     =
        Q15_W'((32'd32440 * 32'd31130 + 32'd16384) >> 15);

    localparam logic [DATA_W-1:0] ADV_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] ADV_MIN = 32'h8000_0000;

    typedef logic [ENV_IN_W-1:0] env_tab_t [ENV_TAB_N];

    typedef struct packed {
        logic [Q15_W-1:0] gamma;
        logic [Q15_W-1:0] gl;
    } cfg_t;

    typedef struct packed {
        logic [ENV_IN_W-1:0]      env;
        logic signed [DATA_W-1:0] reward;
        logic signed [DATA_W-1:0] value;
        logic                     done_req;
        logic signed [DATA_W-1:0] bootstrap_value;
        logic                     rollout_start;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] adv;
        logic signed [DATA_W-1:0] value;
    } state_t;

    typedef struct packed {
        logic [ENV_IN_W-1:0]      env;
        logic signed [DATA_W-1:0] adv;
        logic                     saturated;
    } result_t;

    // index modulo n for every 4-bit env index, by repeated subtraction
    function automatic env_tab_t gar_build_wrap(int n);
        env_tab_t tab;
        int       v;
        for (int i = 0; i < ENV_TAB_N; i++)
        begin
            v = i;
            for (int k = 0; k < ENV_TAB_N; k++)
            begin
                if (v >= n)
                begin
                    v = v - n;
                end
            end
            tab[i] = ENV_IN_W'(v);
        end
        return tab;
    endfunction

endpackage

// ===== rtl/gar_if.sv =====
// Valid/ready stream interfaces for sample input and advantage output.
// Depends on gar_pkg for field widths.
interface gar_in_if import gar_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ENV_IN_W-1:0]      env_index;
    logic signed [DATA_W-1:0] reward;
    logic signed [DATA_W-1:0] value;
    logic                     done_req;
    logic signed [DATA_W-1:0] bootstrap_value;
    logic                     rollout_start;

    modport source (
        output valid, env_index, reward, value, done_req, bootstrap_value, rollout_start,
        input  ready
    );
    modport sink (
        input  valid, env_index, reward, value, done_req, bootstrap_value, rollout_start,
        output ready
    );
endinterface

interface gar_out_if import gar_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ENV_IN_W-1:0]      env_out;
    logic signed [DATA_W-1:0] advantage;
    logic                     saturated;

    modport source (
        output valid, env_out, advantage, saturated,
        input  ready
    );
    modport sink (
        input  valid, env_out, advantage, saturated,
        output ready
    );
endinterface

// ===== rtl/gar_cfg_regs.sv =====
// Configuration registers: gamma and lambda (clamped to 1.0) and the gamma*lambda product.
// Depends on gar_pkg.
module gar_cfg_regs import gar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [CFG_IDX_W-1:0]  index,
    input  logic [CFG_DATA_W-1:0] data,
    output cfg_t                  cfg
);

    logic [Q15_W-1:0] gamma_reg, gamma_next;
    logic [Q15_W-1:0] lambda_reg, lambda_next;
    logic [Q15_W-1:0] gl_reg, gl_next;
    logic [Q15_W-1:0] data_clamped;

    always_comb
    begin
        data_clamped = (data > Q15_ONE) ? Q15_ONE : data;
        gamma_next   = gamma_reg;
        lambda_next  = lambda_reg;
        if (we)
        begin
            case (index)
                CFG_GAMMA:  gamma_next  = data_clamped;
                CFG_LAMBDA: lambda_next = data_clamped;
                default:    ;
            endcase
        end
        gl_next = Q15_W'((32'(gamma_next) * 32'(lambda_next) + 32'd16384) >> 15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg  <= GAMMA_RESET;
            lambda_reg <= LAMBDA_RESET;
            gl_reg     <= GL_RESET;
        end
        else
        begin
            gamma_reg  <= gamma_next;
            lambda_reg <= lambda_next;
            gl_reg     <= gl_next;
        end
    end

    assign cfg.gamma = gamma_reg;
    assign cfg.gl    = gl_reg;

endmodule

// ===== rtl/gar_state_ram.sv =====
// Per-environment state memory: last advantage and later value, registered read.
// Depends on gar_pkg.
module gar_state_ram import gar_pkg::*;
#(
    parameter int DEPTH = ENV_SLOTS_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output state_t                                 rd_data,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  state_t                                 wr_data
);

    state_t mem [DEPTH];
    state_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/gar_datapath.sv =====
// Advantage arithmetic: two Q1.15 products with half-up rounding, sum, saturation.
// Depends on gar_pkg.
module gar_datapath import gar_pkg::*;
(
    input  item_t   item,
    input  state_t  state,
    input  cfg_t    cfg,
    output result_t res
);

    logic signed [DATA_W-1:0]   later_val;
    logic signed [DATA_W-1:0]   prev_adv;
    logic signed [48:0]         prod_v, prod_a;
    logic signed [48:0]         rnd_v, rnd_a;
    logic signed [33:0]         term_v, term_a;
    logic signed [32:0]         delta;
    logic signed [35:0]         sum;
    logic                       sat;

    always_comb
    begin
        later_val = item.rollout_start ? item.bootstrap_value : state.value;
        prev_adv  = item.rollout_start ? '0 : state.adv;

        prod_v = $signed({1'b0, cfg.gamma}) * later_val;
        prod_a = $signed({1'b0, cfg.gl}) * prev_adv;
        rnd_v  = prod_v + 49'sd16384;
        rnd_a  = prod_a + 49'sd16384;
        term_v = rnd_v[48:15];
        term_a = rnd_a[48:15];

        delta = $signed({item.reward[DATA_W-1], item.reward})
              - $signed({item.value[DATA_W-1], item.value});
        sum   = $signed({{3{delta[32]}}, delta});
        if (!item.done_req)
        begin
            sum = sum + $signed({{2{term_v[33]}}, term_v})
                      + $signed({{2{term_a[33]}}, term_a});
        end

        // in range only when the top five bits agree
        sat = !((&sum[35:31]) || !(|sum[35:31]));

        res.env       = item.env;
        res.saturated = sat;
        if (sat)
        begin
            res.adv = sum[35] ? ADV_MIN : ADV_MAX;
        end
        else
        begin
            res.adv = sum[31:0];
        end
    end

endmodule

// ===== rtl/gae_advantage_recurrence_unit.sv =====
// Top level of the GAE advantage recurrence unit: input stage, state memory, output register.
// Depends on gar_pkg, gar_if, gar_cfg_regs, gar_state_ram and gar_datapath.
//
// Takes one sample per clock unless the output is held, and returns one advantage per sample,
// in order. A sample accepted into the input stage sits there while its environment's stored
// advantage and later value come out of the state memory; the advantage is computed there and
// lands in the output register when the stage advances, which a held output result can delay.
// The memory read-modify-write closes through a bypass of the last write, so consecutive
// samples of one environment also run at one per clock unless the output is held; the output
// register lets a new sample in while a finished result waits. No state clearing is done after
// reset: a rollout-start sample must come first for each environment. env_index wraps modulo
// ENV_SLOTS. gamma and lambda above 1.0 are held at 1.0; write them only while the unit is empty.
module gae_advantage_recurrence_unit import gar_pkg::*;
#(
    parameter int ENV_SLOTS = ENV_SLOTS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gar_in_if.sink                in_ch,
    gar_out_if.source             out_ch
);

    localparam int ENV_W = (ENV_SLOTS > 1) ? $clog2(ENV_SLOTS) : 1;
    localparam env_tab_t WRAP_TAB = gar_build_wrap(ENV_SLOTS);

    cfg_t    cfg;
    item_t   s1_item_reg, s1_item_next;
    logic    s1_valid_reg, s1_valid_next;
    result_t out_reg, res;
    logic    out_valid_reg, out_valid_next;
    state_t  rd_state, op_state, wr_state;
    state_t  byp_state_reg;
    logic [ENV_IN_W-1:0] byp_env_reg;
    logic    byp_valid_reg;
    logic    in_fire, s1_adv;

    gar_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    always_comb
    begin
        in_fire = in_ch.valid && in_ch.ready;
        s1_adv  = s1_valid_reg && (!out_valid_reg || out_ch.ready);

        s1_item_next.env             = WRAP_TAB[in_ch.env_index];
        s1_item_next.reward          = in_ch.reward;
        s1_item_next.value           = in_ch.value;
        s1_item_next.done_req        = in_ch.done_req;
        s1_item_next.bootstrap_value = in_ch.bootstrap_value;
        s1_item_next.rollout_start   = in_ch.rollout_start;

        s1_valid_next  = in_fire || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && !out_ch.ready);

        op_state = (byp_valid_reg && (byp_env_reg == s1_item_reg.env)) ? byp_state_reg
                                                                          : rd_state;
        wr_state.adv   = res.adv;
        wr_state.value = s1_item_reg.value;
    end

    assign in_ch.ready = !s1_valid_reg || s1_adv;

    gar_state_ram #(
        .DEPTH (ENV_SLOTS)
    ) u_ram (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (ENV_W'(s1_item_next.env)),
        .rd_data (rd_state),
        .wr_en   (s1_adv),
        .wr_addr (ENV_W'(s1_item_reg.env)),
        .wr_data (wr_state)
    );

    gar_datapath u_dp (
        .item  (s1_item_reg),
        .state (op_state),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= s1_item_next;
        end
        if (s1_adv)
        begin
            out_reg       <= res;
            byp_env_reg   <= s1_item_reg.env;
            byp_state_reg <= wr_state;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.env_out   = out_reg.env;
    assign out_ch.advantage = out_reg.adv;
    assign out_ch.saturated = out_reg.saturated;

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted transfer did not reach the input stage");

    a_bypass_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> byp_valid_reg && (byp_env_reg == $past(s1_item_reg.env)))
        else $error("bypass does not hold the last state write");

    a_sat_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.saturated |->
            (out_ch.advantage == ADV_MAX) || (out_ch.advantage == ADV_MIN))
        else $error("saturated advantage is not a range limit");

    a_cfg_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.gamma <= Q15_ONE) && (cfg.gl <= Q15_ONE))
        else $error("discount register above 1.0");

endmodule
